// ===== hdl/hot_pixel_occupancy_masker_core_assert.svh =====
// assertion macros for the hot pixel masker
// used by the checker module only
`ifndef HOT_PIXEL_OCCUPANCY_MASKER_CORE_ASSERT_SVH
`define HOT_PIXEL_OCCUPANCY_MASKER_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define HPM_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);
// next-cycle implication
`define HPM_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

// ===== hdl/hpm_pkg.sv =====
// shared constants and types of the hot pixel masker
// no dependencies
package hpm_pkg;
  localparam int SENSORS      = 4;
  localparam int MAX_COLS     = 256;
  localparam int MAX_ROWS     = 256;
  localparam int FRAME_DIGITS = 256;
  localparam int SW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int PW = SW + RW + CW;
  localparam int PIXELS = SENSORS * MAX_ROWS * MAX_COLS;
  localparam int FW = $clog2(FRAME_DIGITS);

  typedef logic [PW-1:0] pix_t;

  typedef enum logic [1:0] {
    REQ_DIGIT = 2'd0, REQ_FRAME = 2'd1, REQ_EVENT = 2'd2, REQ_FINISH = 2'd3
  } req_t;

  localparam logic [2:0] ST_GOOD = 3'd0, ST_MASKED = 3'd1, ST_LOW = 3'd2,
                         ST_RANGE = 3'd3, ST_DUP = 3'd4, ST_FULL = 3'd5;

  localparam logic [2:0] CFG_COLS = 3'd0, CFG_ROWS = 3'd1, CFG_THR = 3'd2,
                         CFG_OCC = 3'd3, CFG_EVT = 3'd4;

  // pixel memory port: one read request, one write
  typedef struct packed {
    logic rd;
    pix_t raddr;
    logic we;
    pix_t waddr;
    logic [23:0] whits;
    logic wmask;
  } pmem_req_t;
endpackage

// ===== hdl/hpm_if.sv =====
// valid/ready channel interfaces for the masker
// depends on hpm_pkg
interface hpm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  sensor;
  logic signed [15:0] col_x;
  logic signed [15:0] row_y;
  logic signed [15:0] charge;
  modport source (output valid, req_type, sensor, col_x, row_y, charge, input ready);
  modport sink (input valid, req_type, sensor, col_x, row_y, charge, output ready);
endinterface

interface hpm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [1:0]  sensor_out;
  logic [2:0]  digit_status;
  logic [15:0] frame_hits;
  logic [15:0] frame_good_hits;
  logic [23:0] event_total;
  logic [18:0] masked_total;
  modport source (output valid, result_kind, sensor_out, digit_status, frame_hits,
                  frame_good_hits, event_total, masked_total, input ready);
  modport sink (input valid, result_kind, sensor_out, digit_status, frame_hits,
                frame_good_hits, event_total, masked_total, output ready);
endinterface

interface hpm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/hpm_pixel_mem.sv =====
// per-pixel hit counter and mask memory, registered read
// depends on hpm_pkg
module hpm_pixel_mem import hpm_pkg::*; (
  input  logic        clk,
  input  pmem_req_t   req,
  output logic [23:0] rhits,
  output logic        rmask
);
  logic [24:0] mem [PIXELS];
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= {req.wmask, req.whits};
    end
    if (req.rd) begin
      {rmask, rhits} <= mem[req.raddr];
    end
  end
endmodule

// ===== hdl/hpm_frame_mem.sv =====
// frame digit store: pixel indices accepted in the current frame
// depends on hpm_pkg
module hpm_frame_mem import hpm_pkg::*; (
  input  logic          clk,
  input  logic          we,
  input  logic [FW-1:0] waddr,
  input  pix_t          wdata,
  input  logic [FW-1:0] raddr,
  output pix_t          rdata
);
  pix_t mem [FRAME_DIGITS];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/hot_pixel_occupancy_masker_core.sv =====
// Hot pixel masker by occupancy. One result beat per input beat, one item at a time: the next
// item is taken only after the previous result beat has been accepted.
// After reset a clearing pass writes every pixel entry before the first item is taken. A digit
// rejected on charge or range goes from the check state straight to the output state. An
// accepted digit passes the check, the duplicate scan (which reads the frame store one entry a
// cycle), the pixel entry read and the read-modify-write of its pixel entry, then the output
// state; a duplicate or a full frame ends after the scan. Frame end and event end without sweep
// go from the check state to the output state. A sweep reads and writes back one pixel at a
// time over all sensors and configured rows and columns. The limit product max_occupancy*events
// is formed once per sweep in its own register. Configuration is taken at any time.
// depends on hpm_pkg, hpm_if, hpm_pixel_mem, hpm_frame_mem
module hot_pixel_occupancy_masker_core import hpm_pkg::*; (
  input logic clk,
  input logic rst,
  hpm_in_if.sink    in_ch,
  hpm_out_if.source out_ch,
  hpm_cfg_if.sink   cfg
);
  typedef enum logic [9:0] {
    S_CLR   = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_SCAN  = 10'b0000001000,
    S_CMP   = 10'b0000010000,
    S_RMW   = 10'b0000100000,
    S_LIM   = 10'b0001000000,
    S_SWRD  = 10'b0010000000,
    S_SWWR  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [8:0]  columns, rows;
  logic signed [15:0] charge_threshold;
  logic [15:0] max_occupancy;
  logic [23:0] events_for_mask;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= 9'd256; rows <= 9'd256; charge_threshold <= '0;
      max_occupancy <= 16'd655; events_for_mask <= 24'd20000;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_COLS: columns <= cfg.data[8:0];
        CFG_ROWS: rows <= cfg.data[8:0];
        CFG_THR:  charge_threshold <= cfg.data[15:0];
        CFG_OCC:  max_occupancy <= cfg.data[15:0];
        CFG_EVT:  events_for_mask <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective area, clipped to the memory geometry
  logic [10:0] eff_cols, eff_rows;
  assign eff_cols = ({2'b0, columns} > 11'(MAX_COLS)) ? 11'(MAX_COLS) : {2'b0, columns};
  assign eff_rows = ({2'b0, rows} > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : {2'b0, rows};

  // captured item
  logic [1:0]  kind, sens;
  logic signed [15:0] cx, ry, qv;
  pix_t        pix;

  // frame and global counters
  logic [FW:0]   frame_fill;
  logic [15:0]   frame_all, frame_good;
  logic [23:0]   event_counter;
  logic [18:0]   masked_counter;
  logic [FW:0]   scan_i;
  logic [2:0]    status;
  logic [39:0]   limit;

  // sweep walk
  logic [SW:0]   sw_s;
  logic [10:0]   sw_x, sw_y;
  pix_t          sw_pix;
  logic          sw_done;

  // clear walk
  logic [PW:0]   clr_addr;

  // memories
  pmem_req_t   preq;
  logic [23:0] rhits;
  logic        rmask;
  hpm_pixel_mem u_pmem (.clk(clk), .req(preq), .rhits(rhits), .rmask(rmask));

  logic          fwe;
  pix_t          frdata;
  hpm_frame_mem u_fmem (.clk(clk), .we(fwe), .waddr(frame_fill[FW-1:0]), .wdata(pix),
                        .raddr(scan_i[FW-1:0]), .rdata(frdata));

  // range check on the captured digit
  logic in_range;
  assign in_range = ({1'b0, sens} < 3'(SENSORS)) && !cx[15] && !ry[15] &&
                    ({1'b0, cx} < {6'b0, eff_cols}) && ({1'b0, ry} < {6'b0, eff_rows});

  function automatic pix_t mkpix(input logic [SW:0] s, input logic [10:0] y,
                                 input logic [10:0] x);
    logic [31:0] v;
    v = (32'(s) * 32'(MAX_ROWS) + 32'(y)) * 32'(MAX_COLS) + 32'(x);
    return v[PW-1:0];
  endfunction

  assign sw_pix = mkpix(sw_s, sw_y, sw_x);
  assign sw_done = (sw_x + 11'd1 >= eff_cols) && (sw_y + 11'd1 >= eff_rows) &&
                   (sw_s == (SW+1)'(SENSORS - 1));

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  assign fwe = (state == S_RMW);

  // pixel memory control
  always_comb begin
    preq = '0;
    unique case (state)
      S_CLR: begin
        preq.we = 1'b1;
        preq.waddr = clr_addr[PW-1:0];
      end
      S_CMP: begin
        preq.rd = 1'b1;
        preq.raddr = pix;
      end
      S_RMW: begin
        preq.we = 1'b1;
        preq.waddr = pix;
        preq.whits = (rhits == 24'hFFFFFF) ? rhits : rhits + 24'd1;
        preq.wmask = rmask;
      end
      S_SWRD: begin
        preq.rd = 1'b1;
        preq.raddr = sw_pix;
      end
      S_SWWR: begin
        preq.we = 1'b1;
        preq.waddr = sw_pix;
        preq.whits = rhits;
        preq.wmask = rmask || ({rhits, 16'b0} > limit);
      end
      default: ;
    endcase
  end

  logic sweep_any;
  assign sweep_any = (eff_cols != 11'd0) && (eff_rows != 11'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      frame_fill <= '0; frame_all <= '0; frame_good <= '0;
      event_counter <= '0; masked_counter <= '0;
      out_ch.valid <= 1'b0;
      scan_i <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (PW+1)'(PIXELS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            kind <= in_ch.req_type; sens <= in_ch.sensor;
            cx <= in_ch.col_x; ry <= in_ch.row_y; qv <= in_ch.charge;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          status <= ST_GOOD;
          scan_i <= '0;
          pix <= mkpix({1'b0, sens}, {1'b0, ry[9:0]}, {1'b0, cx[9:0]});
          unique case (kind)
            REQ_DIGIT: begin
              if (frame_all != 16'hFFFF) frame_all <= frame_all + 16'd1;
              if (qv < charge_threshold) begin
                status <= ST_LOW; state <= S_OUT;
              end else if (!in_range) begin
                status <= ST_RANGE; state <= S_OUT;
              end else begin
                state <= S_SCAN;
              end
            end
            REQ_FRAME: state <= S_OUT;
            REQ_EVENT: begin
              if (event_counter != 24'hFFFFFF) begin
                event_counter <= event_counter + 24'd1;
                state <= (event_counter + 24'd1 == events_for_mask) ? S_LIM : S_OUT;
              end else begin
                state <= S_OUT;
              end
            end
            default: state <= S_LIM;
          endcase
        end
        S_SCAN: begin
          // frame store read issued at scan_i, compare next cycle
          if (scan_i >= frame_fill) begin
            if (frame_fill >= (FW+1)'(FRAME_DIGITS)) begin
              status <= ST_FULL; state <= S_OUT;
            end else begin
              state <= S_CMP;
            end
          end else begin
            state <= S_SCAN;
            scan_i <= scan_i + 1'b1;
          end
          if (scan_i != '0 && frdata == pix) begin
            status <= ST_DUP; state <= S_OUT;
          end
        end
        S_CMP: state <= S_RMW;
        S_RMW: begin
          frame_fill <= frame_fill + 1'b1;
          if (rmask) begin
            status <= ST_MASKED;
          end else if (frame_good != 16'hFFFF) begin
            frame_good <= frame_good + 16'd1;
          end
          state <= S_OUT;
        end
        S_LIM: begin
          limit <= 40'(max_occupancy) * 40'(event_counter);
          sw_s <= '0; sw_x <= '0; sw_y <= '0;
          state <= sweep_any ? S_SWRD : S_OUT;
        end
        S_SWRD: state <= S_SWWR;
        S_SWWR: begin
          if (!rmask && ({rhits, 16'b0} > limit) && masked_counter != 19'h7FFFF)
            masked_counter <= masked_counter + 19'd1;
          if (sw_done) begin
            state <= S_OUT;
          end else begin
            state <= S_SWRD;
            if (sw_x + 11'd1 < eff_cols) begin
              sw_x <= sw_x + 11'd1;
            end else begin
              sw_x <= '0;
              if (sw_y + 11'd1 < eff_rows) begin
                sw_y <= sw_y + 11'd1;
              end else begin
                sw_y <= '0;
                sw_s <= sw_s + 1'b1;
              end
            end
          end
        end
        S_OUT: begin
          out_ch.valid <= 1'b1;
          out_ch.result_kind <= kind;
          out_ch.digit_status <= status;
          out_ch.event_total <= event_counter;
          out_ch.masked_total <= masked_counter;
          if (kind == REQ_DIGIT || kind == REQ_FRAME) begin
            out_ch.sensor_out <= sens;
            out_ch.frame_hits <= frame_all;
            out_ch.frame_good_hits <= frame_good;
          end else begin
            out_ch.sensor_out <= '0;
            out_ch.frame_hits <= '0;
            out_ch.frame_good_hits <= '0;
          end
          if (kind == REQ_FRAME) begin
            frame_fill <= '0; frame_all <= '0; frame_good <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/hpm_checker.sv =====
// port-level checks on the masker core, bound into the masker core
// depends on hpm_pkg and hot_pixel_occupancy_masker_core_assert.svh
`include "hot_pixel_occupancy_masker_core_assert.svh"
module hpm_checker import hpm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  digit_status,
  input logic [1:0]  result_kind,
  input logic [15:0] frame_hits,
  input logic [15:0] frame_good_hits
);
  // result beats other than finish results (event results carry zero frame counts)
  logic frame_beat;
  assign frame_beat = out_valid && (result_kind != REQ_FINISH);

  `HPM_ASSERT_IMPL(a_no_take_while_full, clk, rst, out_valid, !in_ready, "take while full")
  `HPM_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `HPM_ASSERT_IMPL(a_status_ok, clk, rst, out_valid, digit_status <= ST_FULL, "bad status")
  `HPM_ASSERT_IMPL(a_good_le_all, clk, rst, frame_beat, frame_good_hits <= frame_hits, "good>all")
  `HPM_ASSERT_NEXT(a_ready_drops, clk, rst, in_valid && in_ready, !in_ready, "ready held")
endmodule

bind hot_pixel_occupancy_masker_core hpm_checker u_hpm_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .digit_status(out_ch.digit_status),
  .result_kind(out_ch.result_kind), .frame_hits(out_ch.frame_hits),
  .frame_good_hits(out_ch.frame_good_hits)
);

// ===== tb/hot_pixel_occupancy_masker_core_test.sv =====
// testbench of the hot pixel occupancy masker: directed and random digit traffic
// results checked against a behavioral predictor of the masking rules
// depends on hpm_pkg, hpm_if and the masker rtl
`timescale 1ns / 1ps

module hot_pixel_occupancy_masker_core_test;
  import hpm_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  sens;
    logic [2:0]  status;
    logic [15:0] all_hits;
    logic [15:0] good_hits;
    logic [23:0] events;
    logic [18:0] masked;
  } masker_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hpm_in_if  in_ch ();
  hpm_out_if out_ch ();
  hpm_cfg_if cfg ();

  hot_pixel_occupancy_masker_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted copy of the block's registers and stores
  int unsigned  cols_reg, rows_reg, occ_reg, evt_reg;
  int           thr_reg;
  bit [23:0]    pixel_hits [PIXELS];
  bit           pixel_mask [PIXELS];
  int unsigned  frame_pixels [FRAME_DIGITS];
  int unsigned  frame_fill, frame_all, frame_good, event_count, mask_count;

  masker_result_t expected_results[$];
  int unsigned    fail_count = 0;
  int unsigned    gap_max = 12;     // sender idle cycles drawn per beat
  int unsigned    stall_max = 12;   // receiver stall cycles drawn per beat

  function automatic int unsigned used_cols();
    return (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
  endfunction

  function automatic int unsigned used_rows();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
  endfunction

  // mask every configured pixel whose hit rate is over the limit, sticky
  function automatic void sweep_pixels();
    longint unsigned limit;
    int unsigned p;
    limit = longint'(occ_reg) * longint'(event_count);
    for (int s = 0; s < SENSORS; s++)
      for (int y = 0; y < used_rows(); y++)
        for (int x = 0; x < used_cols(); x++) begin
          p = (s * MAX_ROWS + y) * MAX_COLS + x;
          if (!pixel_mask[p] && (longint'(pixel_hits[p]) << 16) > limit) begin
            pixel_mask[p] = 1'b1;
            if (mask_count < 19'h7FFFF) mask_count++;
          end
        end
  endfunction

  function automatic logic [2:0] classify_digit(int unsigned s, int x, int y, int q);
    int unsigned p;
    if (frame_all < 16'hFFFF) frame_all++;
    if (q < thr_reg) return ST_LOW;
    if (s >= SENSORS || x < 0 || y < 0 || x >= used_cols() || y >= used_rows())
      return ST_RANGE;
    p = (s * MAX_ROWS + y) * MAX_COLS + x;
    for (int i = 0; i < frame_fill; i++)
      if (frame_pixels[i] == p) return ST_DUP;
    if (frame_fill >= FRAME_DIGITS) return ST_FULL;
    frame_pixels[frame_fill] = p;
    frame_fill++;
    if (pixel_hits[p] < 24'hFFFFFF) pixel_hits[p]++;
    if (pixel_mask[p]) return ST_MASKED;
    if (frame_good < 16'hFFFF) frame_good++;
    return ST_GOOD;
  endfunction

  function automatic masker_result_t predict_result(req_t kind, logic [1:0] s,
      logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] q);
    masker_result_t r;
    r = '0;
    r.kind = kind;
    case (kind)
      REQ_DIGIT: begin
        r.status = classify_digit(int'(s), int'(x), int'(y), int'(q));
        r.sens = s;
        r.all_hits = 16'(frame_all);
        r.good_hits = 16'(frame_good);
      end
      REQ_FRAME: begin
        r.sens = s;
        r.all_hits = 16'(frame_all);
        r.good_hits = 16'(frame_good);
        frame_fill = 0;
        frame_all = 0;
        frame_good = 0;
      end
      REQ_EVENT: begin
        // sweep only when the counter moves onto the trigger value
        if (event_count < 24'hFFFFFF) begin
          event_count++;
          if (event_count == evt_reg) sweep_pixels();
        end
      end
      default: sweep_pixels();
    endcase
    r.events = 24'(event_count);
    r.masked = 19'(mask_count);
    return r;
  endfunction

  // send one beat, keeping valid high into the next beat when there is no gap
  task automatic send_item(req_t kind, logic [1:0] s, logic signed [15:0] x,
      logic signed [15:0] y, logic signed [15:0] q);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= kind;
    in_ch.sensor   <= s;
    in_ch.col_x    <= x;
    in_ch.row_y    <= y;
    in_ch.charge   <= q;
    do @(posedge clk); while (!in_ch.ready);
    expected_results = {expected_results, predict_result(kind, s, x, y, q)};
  endtask

  task automatic send_digit(int s, int x, int y, int q);
    send_item(REQ_DIGIT, s[1:0], x[15:0], y[15:0], q[15:0]);
  endtask

  task automatic send_marker(req_t kind, int s);
    send_item(kind, s[1:0], 16'sd0, 16'sd0, 16'sd0);
  endtask

  // drain outstanding results, then let the block settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write all five registers back to back while the block is idle
  task automatic set_registers(int unsigned c, int unsigned r, int t, int unsigned o,
      int unsigned e);
    logic [23:0] vals [5];
    logic [2:0]  idx [5];
    wait_drained();
    vals = '{24'(c), 24'(r), 24'(t & 16'hFFFF), 24'(o), 24'(e)};
    idx  = '{CFG_COLS, CFG_ROWS, CFG_THR, CFG_OCC, CFG_EVT};
    for (int i = 0; i < 5; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx[i];
      cfg.data  <= vals[i];
      do @(posedge clk); while (!cfg.ready);
    end
    cfg.valid <= 1'b0;
    cols_reg = c & 9'h1FF;
    rows_reg = r & 9'h1FF;
    thr_reg  = int'($signed(t[15:0]));
    occ_reg  = o & 16'hFFFF;
    evt_reg  = e & 24'hFFFFFF;
  endtask

  // reset settings: rejection order, extremes of the fields, full-size finish sweep
  task automatic test_digit_rules();
    send_digit(0, 0, 0, 0);
    send_digit(3, 255, 255, 32767);
    send_digit(0, 0, 0, 5);              // repeat of an accepted pixel
    send_digit(0, 0, 0, -1);             // below threshold wins over repeat
    send_digit(1, 10, 10, -32768);
    send_digit(1, 256, 0, 1);
    send_digit(1, -1, 0, 1);
    send_digit(2, 0, -32768, 1);
    send_digit(2, 0, 32767, 1);
    send_digit(2, 32767, 0, 1);
    send_digit(2, -32768, 300, -32768);  // low charge checked before range
    send_marker(REQ_FRAME, 0);
    send_digit(0, 0, 0, 0);              // repeat scope ends with the frame
    send_marker(REQ_EVENT, 0);
    send_marker(REQ_FRAME, 3);
    send_marker(REQ_FINISH, 0);
    send_digit(0, 0, 0, 7);              // counted on a masked pixel
    send_digit(3, 255, 255, 7);
    send_marker(REQ_FRAME, 1);
  endtask

  // fill the frame store, then one more new pixel and one repeat
  task automatic test_full_frame();
    for (int i = 0; i < FRAME_DIGITS; i++)
      send_digit(1, i % 256, 100 + i / 256, 3);
    send_digit(1, 5, 200, 3);
    send_digit(1, 7, 100, 3);
    send_marker(REQ_FRAME, 1);
  endtask

  // oversized and zero areas, threshold and occupancy extremes, no event trigger
  task automatic test_register_extremes();
    set_registers(511, 300, 32767, 65535, 0);
    send_digit(2, 255, 255, 32767);
    send_digit(2, 254, 255, 32766);
    send_marker(REQ_EVENT, 0);
    send_marker(REQ_FRAME, 2);
    set_registers(0, 0, -32768, 0, 16777215);
    send_digit(0, 0, 0, -32768);
    send_marker(REQ_FINISH, 0);
    send_marker(REQ_EVENT, 0);
    set_registers(256, 1, -32768, 1, 16777215);
    send_digit(3, 200, 0, 0);
    send_digit(3, 200, 1, 0);
    send_marker(REQ_FRAME, 3);
  endtask

  function automatic int charge_near_threshold();
    int q;
    q = thr_reg + int'($urandom_range(0, 300)) - 20;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  // events of sensor frames on a small area, with hot spots and some noise beats
  task automatic test_random_events(int unsigned item_goal);
    int unsigned sent, frames, digits, pick;
    int          s;
    int          hot_x, hot_y;
    sent = 0;
    while (sent < item_goal) begin
      hot_x = $urandom_range(0, used_cols());
      hot_y = $urandom_range(0, used_rows());
      frames = $urandom_range(1, 4);
      for (int f = 0; f < frames; f++) begin
        s = $urandom_range(0, 3);
        digits = $urandom_range(0, 12);
        for (int d = 0; d < digits; d++) begin
          pick = $urandom_range(0, 99);
          if (pick < 15)
            send_item(req_t'($urandom_range(0, 3)), 2'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
          else if (pick < 45)
            send_digit(s, hot_x, hot_y, charge_near_threshold());
          else
            send_digit(s, $urandom_range(0, used_cols()), $urandom_range(0, used_rows()),
                       charge_near_threshold());
          sent++;
        end
        send_marker(REQ_FRAME, s);
        sent++;
      end
      send_marker(REQ_EVENT, 0);
      sent++;
      if ($urandom_range(0, 19) == 0) begin
        send_marker(REQ_FINISH, 0);
        sent++;
      end
    end
  endtask

  // receiver: random stall per result, compare with the oldest prediction
  int unsigned stall_left = 0;

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    masker_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.kind, out_ch.result_kind);
          check_field("sensor_out", want.sens, out_ch.sensor_out);
          check_field("digit_status", want.status, out_ch.digit_status);
          check_field("frame_hits", want.all_hits, out_ch.frame_hits);
          check_field("frame_good_hits", want.good_hits, out_ch.frame_good_hits);
          check_field("event_total", want.events, out_ch.event_total);
          check_field("masked_total", want.masked, out_ch.masked_total);
        end
        stall_left = $urandom_range(0, stall_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_DIGIT;
    in_ch.sensor   <= '0;
    in_ch.col_x    <= '0;
    in_ch.row_y    <= '0;
    in_ch.charge   <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= CFG_COLS;
    cfg.data       <= '0;
    cols_reg = 256; rows_reg = 256; thr_reg = 0; occ_reg = 655; evt_reg = 20000;
    frame_fill = 0; frame_all = 0; frame_good = 0; event_count = 0; mask_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_digit_rules();
    test_full_frame();
    test_register_extremes();

    // random phases: small areas keep sweeps short; trigger a few events ahead
    for (int ph = 0; ph < 6; ph++) begin
      gap_max   = (ph % 3 == 0) ? 0 : 12;
      stall_max = (ph % 3 == 1) ? 0 : 12;
      if (ph == 0)
        set_registers(1, 1, 0, 0, event_count + 2);
      else if (ph == 5)
        set_registers(16, 8, int'($urandom_range(0, 200)) - 100, 65535, 0);
      else
        set_registers($urandom_range(1, 16), $urandom_range(1, 8),
                      int'($urandom_range(0, 200)) - 100, $urandom_range(0, 40000),
                      event_count + $urandom_range(1, 8));
      test_random_events(100);
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // clearing pass and one full-size sweep dominate; allow several times over
  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
